// ===== hdl/fpvr_pkg.sv =====
// fpvr_pkg: shared widths, constants and elaboration-time helpers for the vector rotator
// holds the fixed-point sine series used to build the sine rom contents
// no dependencies
package fpvr_pkg;

  // field widths
  localparam int DATA_W  = 32;
  localparam int ANGLE_W = 16;
  localparam int TAB_W   = 16;

  // pi in q2.30
  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  // one term of the sine taylor series: term * x^2 / ((2k)(2k+1))
  function automatic logic [63:0] term_next(input logic [63:0] term,
                                            input logic [63:0] x2,
                                            input logic [3:0]  k);
    logic [63:0] prod;
    logic [63:0] res;
    prod = (term * x2) >> 30;
    unique case (k)
      4'd1:    res = prod / 64'd6;
      4'd2:    res = prod / 64'd20;
      4'd3:    res = prod / 64'd42;
      4'd4:    res = prod / 64'd72;
      4'd5:    res = prod / 64'd110;
      4'd6:    res = prod / 64'd156;
      4'd7:    res = prod / 64'd210;
      4'd8:    res = prod / 64'd272;
      4'd9:    res = prod / 64'd342;
      4'd10:   res = prod / 64'd420;
      4'd11:   res = prod / 64'd506;
      4'd12:   res = prod / 64'd600;
      4'd13:   res = prod / 64'd702;
      4'd14:   res = prod / 64'd812;
      4'd15:   res = prod / 64'd930;
      default: res = 64'd0;
    endcase
    return res;
  endfunction

  // sine of a first-quadrant angle given in q2.30 radians, rounded to 2.14
  function automatic logic [15:0] quarter_sine(input logic [63:0] xq);
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        rnd;
    int                 k;
    x2   = (xq * xq) >> 30;
    term = xq;
    sum  = $signed(xq);
    for (k = 1; k <= 15; k++) begin
      term = term_next(term, x2, k[3:0]);
      if (k[0]) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = 64'sd0;
    end
    rnd = ($unsigned(sum) * 64'd16384 + (64'd1 << 29)) >> 30;
    return rnd[15:0];
  endfunction

endpackage

// ===== hdl/fpvr_angle_reduce.sv =====
// fpvr_angle_reduce: reduces the signed angle modulo the step count into sine and cosine indices
// two register stages: reciprocal quotient estimate, then remainder with one correction
// depends on fpvr_pkg
module fpvr_angle_reduce #(
  parameter int ANGLE_STEPS = 512
) (
  input  logic                               clk,
  input  logic [fpvr_pkg::ANGLE_W-1:0]       angle,
  output logic [$clog2(ANGLE_STEPS)-1:0]     sin_idx,
  output logic [$clog2(ANGLE_STEPS)-1:0]     cos_idx
);

  localparam int IW      = $clog2(ANGLE_STEPS);
  localparam int QUARTER = ANGLE_STEPS / 4;
  // smallest multiple of the step count that makes every angle non-negative
  localparam int OFFSET  = ((32768 + ANGLE_STEPS - 1) / ANGLE_STEPS) * ANGLE_STEPS;
  localparam int VMAX    = 32767 + OFFSET + QUARTER;
  localparam int VW      = $clog2(VMAX + 1);
  localparam int RECIP   = (2 ** VW) / ANGLE_STEPS;
  localparam int RW      = $clog2(RECIP + 1);
  localparam int PW      = VW + RW;

  localparam logic [VW-1:0] OFFSET_V  = VW'(OFFSET);
  localparam logic [VW-1:0] QUARTER_V = VW'(QUARTER);
  localparam logic [VW-1:0] STEPS_V   = VW'(ANGLE_STEPS);
  localparam logic [PW-1:0] RECIP_V   = PW'(RECIP);

  logic [VW-1:0] v_sin_next, v_cos_next;
  logic [PW-1:0] p_sin, p_cos;
  logic [VW-1:0] v_sin, v_cos;
  logic [RW-1:0] q_sin, q_cos;
  logic [VW-1:0] r_sin, r_cos;
  logic [VW-1:0] m_sin, m_cos;

  // shift angle into a non-negative range, then estimate the quotient
  assign v_sin_next = {{(VW - fpvr_pkg::ANGLE_W){angle[fpvr_pkg::ANGLE_W-1]}}, angle}
                      + OFFSET_V;
  assign v_cos_next = v_sin_next + QUARTER_V;
  assign p_sin      = PW'(v_sin_next) * RECIP_V;
  assign p_cos      = PW'(v_cos_next) * RECIP_V;

  always_ff @(posedge clk) begin
    v_sin <= v_sin_next;
    v_cos <= v_cos_next;
    q_sin <= p_sin[PW-1:VW];
    q_cos <= p_cos[PW-1:VW];
  end

  // remainder lands below twice the step count, one subtract fixes it
  assign r_sin = v_sin - VW'(VW'(q_sin) * STEPS_V);
  assign r_cos = v_cos - VW'(VW'(q_cos) * STEPS_V);
  assign m_sin = (r_sin >= STEPS_V) ? (r_sin - STEPS_V) : r_sin;
  assign m_cos = (r_cos >= STEPS_V) ? (r_cos - STEPS_V) : r_cos;

  always_ff @(posedge clk) begin
    sin_idx <= m_sin[IW-1:0];
    cos_idx <= m_cos[IW-1:0];
  end

endmodule

// ===== hdl/fpvr_sine_rom.sv =====
// fpvr_sine_rom: full-circle sine table in 2.14, two registered read ports
// contents built at elaboration from the quarter-wave series in fpvr_pkg
// depends on fpvr_pkg
module fpvr_sine_rom #(
  parameter int ANGLE_STEPS = 512
) (
  input  logic                             clk,
  input  logic [$clog2(ANGLE_STEPS)-1:0]   sin_idx,
  input  logic [$clog2(ANGLE_STEPS)-1:0]   cos_idx,
  output logic [fpvr_pkg::TAB_W-1:0]       sin_val,
  output logic [fpvr_pkg::TAB_W-1:0]       cos_val
);

  localparam logic [63:0] N64   = 64'(ANGLE_STEPS);
  localparam logic [63:0] TWO_N = 64'(2 * ANGLE_STEPS);

  logic [fpvr_pkg::TAB_W-1:0] sine_rom [ANGLE_STEPS];

  // fold each entry into the first quadrant and evaluate the series
  for (genvar i = 0; i < ANGLE_STEPS; i++) begin : g_entry
    localparam logic [63:0] U0   = 64'(4 * i);
    localparam bit          NEG  = (U0 >= TWO_N);
    localparam logic [63:0] U1   = NEG ? (U0 - TWO_N) : U0;
    localparam logic [63:0] U    = (U1 > N64) ? (TWO_N - U1) : U1;
    localparam logic [63:0] XQ   = (U * fpvr_pkg::PI_Q30) / TWO_N;
    localparam logic [15:0] VAL  = fpvr_pkg::quarter_sine(XQ);
    localparam logic [15:0] ENTRY = NEG ? (16'd0 - VAL) : VAL;
    assign sine_rom[i] = ENTRY;
  end

  // registered reads
  always_ff @(posedge clk) begin
    sin_val <= sine_rom[sin_idx];
    cos_val <= sine_rom[cos_idx];
  end

endmodule

// ===== hdl/fpvr_fx_mul.sv =====
// fpvr_fx_mul: multiplies a 32-bit integer by a 2.14 table value taken as 16.16
// two register stages: partial products, then shift and add, all wrapping at 32 bits
// depends on fpvr_pkg
module fpvr_fx_mul (
  input  logic                          clk,
  input  logic [fpvr_pkg::DATA_W-1:0]   a,
  input  logic [fpvr_pkg::TAB_W-1:0]    t,
  output logic [fpvr_pkg::DATA_W-1:0]   p
);

  localparam int DW = fpvr_pkg::DATA_W;

  logic [15:0]   lo;
  logic [DW-1:0] hi_term_next;
  logic [DW-1:0] lo_prod_next;
  logic [DW-1:0] hi_term, lo_prod;

  // fraction half of the widened value; the integer half is t >>> 14, in -2 .. 1
  assign lo           = {t[13:0], 2'b00};
  assign lo_prod_next = DW'(a * {16'd0, lo});

  always_comb begin
    unique case (t[15:14])
      2'b00: hi_term_next = '0;
      2'b01: hi_term_next = a;
      2'b11: hi_term_next = '0 - a;
      2'b10: hi_term_next = '0 - {a[DW-2:0], 1'b0};
    endcase
  end

  always_ff @(posedge clk) begin
    hi_term <= hi_term_next;
    lo_prod <= lo_prod_next;
  end

  // arithmetic shift of the fraction product, then add the integer part
  always_ff @(posedge clk) begin
    p <= hi_term + {{16{lo_prod[DW-1]}}, lo_prod[DW-1:16]};
  end

endmodule

// ===== hdl/fixed_point_vector_rotate.sv =====
// fixed_point_vector_rotate: rotates a signed 32-bit vector by a table-driven angle
// x' = x*cos - y*sin, y' = x*sin + y*cos, all products and sums wrapping at 32 bits
// depends on fpvr_pkg, fpvr_angle_reduce, fpvr_sine_rom, fpvr_fx_mul
//
//   channel   | handshake        | payload
//   ----------+------------------+-------------------------------
//   command   | start / busy     | vec_x[31:0] vec_y[31:0] angle[15:0]
//   result    | done (1 cycle)   | rot_x[31:0] rot_y[31:0]
//
// one transaction can be taken every cycle; busy is always low
// done and the result are set together by seven register stages:
//   input register, quotient estimate, index remainder, sine rom read,
//   partial products, shift and add, output sum
// rst clears the valid pipeline and done; no clearing pass, the rom is constant
// the receiver cannot stall: done marks each result for exactly one cycle
module fixed_point_vector_rotate #(
  parameter int ANGLE_STEPS = 512
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [fpvr_pkg::DATA_W-1:0]  vec_x,
  input  logic signed [fpvr_pkg::DATA_W-1:0]  vec_y,
  input  logic signed [fpvr_pkg::ANGLE_W-1:0] angle,
  output logic                                done,
  output logic signed [fpvr_pkg::DATA_W-1:0]  rot_x,
  output logic signed [fpvr_pkg::DATA_W-1:0]  rot_y
);

  localparam int DW    = fpvr_pkg::DATA_W;
  localparam int TW    = fpvr_pkg::TAB_W;
  localparam int IW    = $clog2(ANGLE_STEPS);
  // valid stages from the input register up to the one before the output register
  localparam int DEPTH = 6;

  logic [DEPTH-1:0]              vld;
  logic [DW-1:0]                 x1, y1, x2, y2, x3, y3, x4, y4;
  logic [fpvr_pkg::ANGLE_W-1:0]  angle1;
  logic [IW-1:0]                 sin_idx, cos_idx;
  logic [TW-1:0]                 sin_val, cos_val;
  logic [DW-1:0]                 p_xc, p_ys, p_xs, p_yc;

  assign busy = 1'b0;

  // valid pipeline and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[DEPTH-2:0], start & ~busy};
      done <= vld[DEPTH-1];
    end
  end

  // input register and vector delay line to meet the table values
  always_ff @(posedge clk) begin
    x1     <= vec_x;
    y1     <= vec_y;
    angle1 <= angle;
    x2     <= x1;
    y2     <= y1;
    x3     <= x2;
    y3     <= y2;
    x4     <= x3;
    y4     <= y3;
  end

  // angle to sine and cosine indices
  fpvr_angle_reduce #(
    .ANGLE_STEPS (ANGLE_STEPS)
  ) u_reduce (
    .clk     (clk),
    .angle   (angle1),
    .sin_idx (sin_idx),
    .cos_idx (cos_idx)
  );

  // table lookup
  fpvr_sine_rom #(
    .ANGLE_STEPS (ANGLE_STEPS)
  ) u_rom (
    .clk     (clk),
    .sin_idx (sin_idx),
    .cos_idx (cos_idx),
    .sin_val (sin_val),
    .cos_val (cos_val)
  );

  // four fixed-point products
  fpvr_fx_mul u_mul_xc (.clk(clk), .a(x4), .t(cos_val), .p(p_xc));
  fpvr_fx_mul u_mul_ys (.clk(clk), .a(y4), .t(sin_val), .p(p_ys));
  fpvr_fx_mul u_mul_xs (.clk(clk), .a(x4), .t(sin_val), .p(p_xs));
  fpvr_fx_mul u_mul_yc (.clk(clk), .a(y4), .t(cos_val), .p(p_yc));

  // output register
  always_ff @(posedge clk) begin
    rot_x <= p_xc - p_ys;
    rot_y <= p_xs + p_yc;
  end

endmodule
